>>> rtl/srr_pkg.sv
package srr_pkg;

	localparam logic [1:0] KIND_ACK     = 2'd0;
	localparam logic [1:0] KIND_DELIVER = 2'd1;
	localparam logic [1:0] KIND_RESEND  = 2'd2;
	localparam logic [1:0] KIND_DROPPED = 2'd3;

	typedef struct packed {
		logic [31:0] session_key;
		logic [31:0] packet_index;
		logic [31:0] sender_verified;
		logic [7:0]  command_code;
		logic [15:0] payload_tag;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] seq_index;
		logic [31:0] range_end;
		logic [7:0]  command_out;
		logic [15:0] tag_out;
		logic        last_of_run;
	} out_item_t;

	// control broadcast along the cell row
	typedef struct packed {
		logic clr;
		logic ins;
		logic del;
	} cell_ctl_t;

endpackage

>>> rtl/srr_in_if.sv
interface srr_in_if
	import srr_pkg::*;
	;
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/srr_out_if.sv
interface srr_out_if
	import srr_pkg::*;
	;
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/srr_cell.sv
module srr_cell
	import srr_pkg::*;
#(
	parameter int IW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cell_ctl_t     ctl,
	input  logic [IW-1:0] key,
	input  logic [7:0]    ins_cmd,
	input  logic [15:0]   ins_tag,
	input  logic          taken_in,
	output logic          taken_out,
	input  logic          hit_in,
	output logic          hit_out,
	input  logic [7:0]    cmd_in,
	output logic [7:0]    cmd_out,
	input  logic [15:0]   tag_in,
	output logic [15:0]   tag_out
);

	logic          valid_q;
	logic [IW-1:0] index_q;
	logic [7:0]    cmd_q;
	logic [15:0]   tag_q;
	logic          hit;
	logic          claim;

	assign hit       = valid_q && (index_q == key);
	// lowest free cell claims the insert, the rest see it taken
	assign claim     = ctl.ins && !taken_in && !valid_q;
	assign taken_out = taken_in | ~valid_q;
	assign hit_out   = hit_in | hit;
	assign cmd_out   = cmd_in | (hit ? cmd_q : 8'd0);
	assign tag_out   = tag_in | (hit ? tag_q : 16'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clr) begin
			valid_q <= 1'b0;
		end else if (claim) begin
			valid_q <= 1'b1;
		end else if (ctl.del && hit) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (claim) begin
			index_q <= key;
			cmd_q   <= ins_cmd;
			tag_q   <= ins_tag;
		end
	end

endmodule

>>> rtl/sequence_reorder_receiver_top.sv
// Reorder receiver for one link: a packet is taken, compared with the session and the
// last processed index, then acknowledged, delivered or cached in a row of CACHE_SLOTS
// cells searched combinationally. An early packet is dropped when no cell is free, and
// every early packet also asks for a resend of the missing range. Results leave through
// a single output register with last_of_run on the final one of each packet. A new
// packet is taken only in idle; the search and the free-slot choice ripple along the row.
module sequence_reorder_receiver_top
	import srr_pkg::*;
#(
	parameter int CACHE_SLOTS = 16,
	parameter int INDEX_BITS  = 32
) (
	input logic        clk,
	input logic        arst_n,
	srr_in_if.sink     in,
	srr_out_if.source  out
);

	localparam int IW = INDEX_BITS;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EVAL  = 3'd1;
	localparam logic [2:0] S_CLASS = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_RANGE = 3'd4;

	function automatic logic [31:0] to32(input logic [IW-1:0] v);
		logic [IW+31:0] t;
		t = {32'd0, v};
		return t[31:0];
	endfunction

	function automatic logic [IW-1:0] from32(input logic [31:0] v);
		logic [IW+31:0] t;
		t = {{IW{1'b0}}, v};
		return t[IW-1:0];
	endfunction

	logic [2:0]    state_q;
	logic [31:0]   key_q, session_id_q;
	logic          seen_q;
	logic [IW-1:0] idx_q, ver_q, last_done_q;
	logic [7:0]    cmd_q, pend_cmd_q;
	logic [15:0]   tag_q, pend_tag_q;
	logic          out_valid_q;
	out_item_t     out_q;

	cell_ctl_t     ctl;
	logic [IW-1:0] key;
	logic [IW-1:0] nxt;
	logic [IW-1:0] ld0;
	logic          can_emit;
	logic          emit;
	out_item_t     emit_d;

	logic          taken [CACHE_SLOTS+1];
	logic          hitc  [CACHE_SLOTS+1];
	logic [7:0]    cmdc  [CACHE_SLOTS+1];
	logic [15:0]   tagc  [CACHE_SLOTS+1];

	assign taken[0] = 1'b0;
	assign hitc[0]  = 1'b0;
	assign cmdc[0]  = 8'd0;
	assign tagc[0]  = 16'd0;

	for (genvar i = 0; i < CACHE_SLOTS; i++) begin : g_cell
		srr_cell #(.IW(IW)) u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl), .key(key),
			.ins_cmd(cmd_q), .ins_tag(tag_q),
			.taken_in(taken[i]), .taken_out(taken[i+1]),
			.hit_in(hitc[i]), .hit_out(hitc[i+1]),
			.cmd_in(cmdc[i]), .cmd_out(cmdc[i+1]),
			.tag_in(tagc[i]), .tag_out(tagc[i+1])
		);
	end

	logic hit_any, full;
	assign hit_any = hitc[CACHE_SLOTS];
	assign full    = taken[CACHE_SLOTS] == 1'b0 ? 1'b1 : 1'b0;

	assign nxt      = last_done_q + 1'b1;
	assign key      = (state_q == S_DRAIN) ? nxt : idx_q;
	assign can_emit = !out_valid_q || out.ready;
	assign in.ready = (state_q == S_IDLE);
	assign out.valid = out_valid_q;
	assign out.data  = out_q;

	logic new_session;
	assign new_session = !seen_q || (key_q != session_id_q);
	assign ld0 = new_session ? '0 : last_done_q;

	always_comb begin
		ctl    = '0;
		emit   = 1'b0;
		emit_d = '0;
		unique case (state_q)
			S_EVAL: ctl.clr = new_session;
			S_CLASS: begin
				if (idx_q == nxt) begin
					// in order: wait for the drain search before emitting
				end else if (idx_q <= last_done_q) begin
					emit               = can_emit;
					emit_d.kind        = KIND_ACK;
					emit_d.seq_index   = to32(idx_q);
					emit_d.last_of_run = 1'b1;
				end else if (!hit_any && !full) begin
					ctl.ins = 1'b1;
				end else if (!hit_any) begin
					emit             = can_emit;
					emit_d.kind      = KIND_DROPPED;
					emit_d.seq_index = to32(idx_q);
					emit_d.tag_out   = tag_q;
				end
			end
			S_DRAIN: begin
				emit               = can_emit;
				ctl.del            = can_emit;
				emit_d.kind        = KIND_DELIVER;
				emit_d.seq_index   = to32(last_done_q);
				emit_d.command_out = pend_cmd_q;
				emit_d.tag_out     = pend_tag_q;
				emit_d.last_of_run = !hit_any;
			end
			S_RANGE: begin
				emit               = can_emit;
				emit_d.kind        = KIND_RESEND;
				emit_d.seq_index   = to32(ver_q + 1'b1);
				emit_d.range_end   = to32(idx_q - 1'b1);
				emit_d.last_of_run = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			seen_q       <= 1'b0;
			session_id_q <= '0;
			last_done_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in.valid) state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (new_session) begin
						session_id_q <= key_q;
						seen_q       <= 1'b1;
					end
					last_done_q <= (ver_q > ld0) ? ver_q : ld0;
					state_q     <= S_CLASS;
				end
				S_CLASS: begin
					if (idx_q == nxt) begin
						last_done_q <= idx_q;
						state_q     <= S_DRAIN;
					end else if (idx_q <= last_done_q) begin
						if (can_emit) state_q <= S_IDLE;
					end else if (!hit_any && full) begin
						if (can_emit) state_q <= S_RANGE;
					end else begin
						state_q <= S_RANGE;
					end
				end
				S_DRAIN: begin
					if (can_emit) begin
						if (hit_any) begin
							last_done_q <= nxt;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_RANGE: begin
					if (can_emit) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			key_q <= in.data.session_key;
			idx_q <= from32(in.data.packet_index);
			ver_q <= from32(in.data.sender_verified);
			cmd_q <= in.data.command_code;
			tag_q <= in.data.payload_tag;
		end
		if (state_q == S_CLASS) begin
			pend_cmd_q <= cmd_q;
			pend_tag_q <= tag_q;
		end else if (state_q == S_DRAIN && can_emit) begin
			// successor read from the cell that hit
			pend_cmd_q <= cmdc[CACHE_SLOTS];
			pend_tag_q <= tagc[CACHE_SLOTS];
		end
		if (emit) begin
			out_q <= emit_d;
		end
	end

endmodule
